@@ hdl/bhp_pkg.sv @@
// Shared types, codes and constants of the bucket histogram percentile block.
`timescale 1ns / 1ps
`default_nettype none
package bhp_pkg;

	localparam logic [2:0] KIND_LOAD    = 3'd0;
	localparam logic [2:0] KIND_TOTAL   = 3'd1;
	localparam logic [2:0] KIND_OBSERVE = 3'd2;
	localparam logic [2:0] KIND_QUERY   = 3'd3;
	localparam logic [2:0] KIND_CLEAR   = 3'd4;

	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_UNDEF = 2'd1;
	localparam logic [1:0] STAT_EMPTY = 2'd2;

	localparam logic [13:0] PERCENT_FULL = 14'd10000;
	localparam logic [31:0] COUNT_MAX    = 32'hFFFF_FFFF;

	typedef struct packed {
		logic [2:0]         kind;
		logic [6:0]         hist_sel;
		logic [4:0]         bucket_index;
		logic [5:0]         bucket_total;
		logic signed [31:0] sample;
		logic [13:0]        percent;
	} req_t;

	typedef struct packed {
		logic signed [31:0] answer;
		logic [1:0]         status;
	} rsp_t;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_DISPATCH,
		ST_ZERO,
		ST_CLEAR,
		ST_DECIDE,
		ST_WALK,
		ST_DRAIN,
		ST_FINISH,
		ST_REPLY
	} state_t;

	typedef struct packed {
		logic       take;
		logic       load_bound;
		logic       define;
		logic       zero_step;
		logic       sweep_step;
		logic       sweep_meta;
		logic       decide;
		logic       walk_step;
		logic       finish;
		logic       rsp_load;
		logic [1:0] rsp_status;
	} cmd_t;

	typedef struct packed {
		logic [2:0] kind;
		logic       id_ok;
		logic       bidx_ok;
		logic       defined;
		logic       empty;
		logic       n_zero;
		logic       zero_last;
		logic       walk_last;
		logic       sweep_last;
		logic       pipe_busy;
		logic       rsp_room;
	} sts_t;

endpackage
`default_nettype wire

@@ hdl/bhp_ctrl.sv @@
// Controller state machine: sequences each item through the datapath.
`timescale 1ns / 1ps
`default_nettype none
module bhp_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_stall,
	input  wire bhp_pkg::sts_t sts,
	output bhp_pkg::cmd_t      cmd
);

	bhp_pkg::state_t state_q, state_d;
	logic [1:0]      rstat_q, rstat_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bhp_pkg::ST_INIT;
			rstat_q <= bhp_pkg::STAT_OK;
		end else begin
			state_q <= state_d;
			rstat_q <= rstat_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		rstat_d = rstat_q;
		case (state_q)
			bhp_pkg::ST_INIT: begin
				if (sts.sweep_last) state_d = bhp_pkg::ST_IDLE;
			end
			bhp_pkg::ST_IDLE: begin
				if (req_valid) state_d = bhp_pkg::ST_DISPATCH;
			end
			bhp_pkg::ST_DISPATCH: begin
				rstat_d = bhp_pkg::STAT_OK;
				state_d = bhp_pkg::ST_REPLY;
				if (sts.kind inside {bhp_pkg::KIND_LOAD, bhp_pkg::KIND_TOTAL,
						bhp_pkg::KIND_OBSERVE, bhp_pkg::KIND_QUERY}) begin
					if (!sts.id_ok) begin
						rstat_d = bhp_pkg::STAT_UNDEF;
					end else if (sts.kind == bhp_pkg::KIND_TOTAL) begin
						state_d = bhp_pkg::ST_ZERO;
					end else if (sts.kind != bhp_pkg::KIND_LOAD) begin
						state_d = bhp_pkg::ST_DECIDE;
					end
				end else if (sts.kind == bhp_pkg::KIND_CLEAR) begin
					state_d = bhp_pkg::ST_CLEAR;
				end
			end
			bhp_pkg::ST_ZERO: begin
				if (sts.zero_last) state_d = bhp_pkg::ST_REPLY;
			end
			bhp_pkg::ST_CLEAR: begin
				if (sts.sweep_last) state_d = bhp_pkg::ST_REPLY;
			end
			bhp_pkg::ST_DECIDE: begin
				if (!sts.defined) begin
					rstat_d = bhp_pkg::STAT_UNDEF;
					state_d = bhp_pkg::ST_REPLY;
				end else if (sts.kind == bhp_pkg::KIND_QUERY && sts.empty) begin
					rstat_d = bhp_pkg::STAT_EMPTY;
					state_d = bhp_pkg::ST_REPLY;
				end else if (sts.n_zero) begin
					state_d = bhp_pkg::ST_DRAIN;
				end else begin
					state_d = bhp_pkg::ST_WALK;
				end
			end
			bhp_pkg::ST_WALK: begin
				if (sts.walk_last) state_d = bhp_pkg::ST_DRAIN;
			end
			bhp_pkg::ST_DRAIN: begin
				if (!sts.pipe_busy) state_d = bhp_pkg::ST_FINISH;
			end
			bhp_pkg::ST_FINISH: begin
				state_d = bhp_pkg::ST_REPLY;
			end
			bhp_pkg::ST_REPLY: begin
				if (sts.rsp_room) state_d = bhp_pkg::ST_IDLE;
			end
			default: begin
				state_d = bhp_pkg::ST_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		cmd = '0;
		cmd.rsp_status = rstat_q;
		req_stall = 1'b1;
		case (state_q)
			bhp_pkg::ST_INIT: begin
				cmd.sweep_step = 1'b1;
				cmd.sweep_meta = 1'b1;
			end
			bhp_pkg::ST_IDLE: begin
				req_stall = 1'b0;
				cmd.take  = req_valid;
			end
			bhp_pkg::ST_DISPATCH: begin
				cmd.load_bound = sts.kind == bhp_pkg::KIND_LOAD && sts.id_ok && sts.bidx_ok;
				cmd.define     = sts.kind == bhp_pkg::KIND_TOTAL && sts.id_ok;
			end
			bhp_pkg::ST_ZERO:  cmd.zero_step = 1'b1;
			bhp_pkg::ST_CLEAR: cmd.sweep_step = 1'b1;
			bhp_pkg::ST_DECIDE: begin
				cmd.decide = sts.defined && !(sts.kind == bhp_pkg::KIND_QUERY && sts.empty);
			end
			bhp_pkg::ST_WALK:   cmd.walk_step = 1'b1;
			bhp_pkg::ST_FINISH: cmd.finish = 1'b1;
			bhp_pkg::ST_REPLY:  cmd.rsp_load = sts.rsp_room;
			default: begin
				cmd.rsp_load = 1'b0;
			end
		endcase
	end

endmodule
`default_nettype wire

@@ hdl/bhp_datapath.sv @@
// Datapath: bound, count and per-histogram memories, bucket walk pipeline, result register.
`timescale 1ns / 1ps
`default_nettype none
module bhp_datapath #(
	parameter int NUM_HISTOGRAMS = 128,
	parameter int MAX_BUCKETS    = 32
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire bhp_pkg::req_t req,
	input  wire bhp_pkg::cmd_t cmd,
	output bhp_pkg::sts_t      sts,
	input  wire logic          rsp_stall,
	output logic               rsp_valid,
	output bhp_pkg::rsp_t      rsp
);

	localparam int ENT = NUM_HISTOGRAMS * MAX_BUCKETS;
	localparam int HW  = (NUM_HISTOGRAMS > 1) ? $clog2(NUM_HISTOGRAMS) : 1;
	localparam int AW  = (ENT > 1) ? $clog2(ENT) : 1;
	localparam int TW  = $clog2(MAX_BUCKETS + 1);
	localparam int PW  = 46;
	localparam int ACW = PW + TW + 1;

	bhp_pkg::req_t item_q;
	logic [HW-1:0] h;
	logic [AW-1:0] base, rd_addr;
	logic          id_ok, bidx_ok;
	logic [TW-1:0] total_cap;
	logic [13:0]   pclamp;

	logic [31:0]   bound_mem [ENT];
	logic [31:0]   cnt_mem [ENT];
	logic [TW:0]   meta_mem [NUM_HISTOGRAMS];
	logic [95:0]   stat_mem [NUM_HISTOGRAMS];

	logic [TW:0]   meta_rd_q;
	logic [95:0]   stat_rd_q;
	logic [AW-1:0] sweep_q;
	logic          sweep_in_nh;
	logic [TW-1:0] b_q, n_q;

	logic          v_s1, v_s2;
	logic [AW-1:0] addr_s1;
	logic [31:0]   bound_s1, cnt_s1, bound_s2;
	logic [PW-1:0] prod_s2, x_q;
	logic [ACW-1:0] acc_q, acc_next;
	logic          found_q;
	logic [31:0]   ans_q, last_q, count_q;
	logic [63:0]   sum_q;

	logic          cnt_we, upd;
	logic [AW-1:0] cnt_wa;
	logic [31:0]   cnt_wd;
	logic          rsp_valid_q;
	bhp_pkg::rsp_t rsp_q;

	assign h         = HW'(item_q.hist_sel);
	assign base      = AW'(h) * AW'(MAX_BUCKETS);
	assign rd_addr   = base + AW'(b_q);
	assign id_ok     = {4'd0, item_q.hist_sel} < 11'(NUM_HISTOGRAMS);
	assign bidx_ok   = {2'd0, item_q.bucket_index} < 7'(MAX_BUCKETS);
	assign total_cap = ({1'b0, item_q.bucket_total} > 7'(MAX_BUCKETS)) ?
		TW'(MAX_BUCKETS) : TW'(item_q.bucket_total);
	assign pclamp    = (item_q.percent > bhp_pkg::PERCENT_FULL) ?
		bhp_pkg::PERCENT_FULL : item_q.percent;
	assign sweep_in_nh = {1'b0, sweep_q} < (AW + 1)'(NUM_HISTOGRAMS);

	always_ff @(posedge clk) begin
		if (cmd.take) item_q <= req;
	end

	// memory reads, registered
	always_ff @(posedge clk) begin
		bound_s1  <= bound_mem[rd_addr];
		cnt_s1    <= cnt_mem[rd_addr];
		meta_rd_q <= meta_mem[h];
		stat_rd_q <= stat_mem[h];
	end

	always_ff @(posedge clk) begin
		if (cmd.load_bound) bound_mem[base + AW'(item_q.bucket_index)] <= item_q.sample;
	end

	// observe: bump every walked bucket whose bound is at least the sample
	assign upd = v_s1 && item_q.kind == bhp_pkg::KIND_OBSERVE
		&& item_q.sample <= $signed(bound_s1);

	always_comb begin
		cnt_we = 1'b0;
		cnt_wa = addr_s1;
		cnt_wd = '0;
		if (cmd.sweep_step) begin
			cnt_we = 1'b1;
			cnt_wa = sweep_q;
		end else if (cmd.zero_step) begin
			cnt_we = 1'b1;
			cnt_wa = rd_addr;
		end else if (upd) begin
			cnt_we = 1'b1;
			cnt_wd = (cnt_s1 == bhp_pkg::COUNT_MAX) ? cnt_s1 : cnt_s1 + 32'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cnt_we) cnt_mem[cnt_wa] <= cnt_wd;
	end

	always_ff @(posedge clk) begin
		if (cmd.sweep_step && cmd.sweep_meta && sweep_in_nh) begin
			meta_mem[sweep_q[HW-1:0]] <= '0;
		end else if (cmd.define) begin
			meta_mem[h] <= {1'b1, total_cap};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sweep_step && sweep_in_nh) begin
			stat_mem[sweep_q[HW-1:0]] <= '0;
		end else if (cmd.define) begin
			stat_mem[h] <= '0;
		end else if (cmd.finish && item_q.kind == bhp_pkg::KIND_OBSERVE) begin
			stat_mem[h] <= {(count_q == bhp_pkg::COUNT_MAX) ? count_q : count_q + 32'd1,
				sum_q + 64'(item_q.sample)};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q <= '0;
			b_q     <= '0;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
		end else begin
			if (cmd.sweep_step) sweep_q <= sts.sweep_last ? '0 : sweep_q + AW'(1);
			if (cmd.define || cmd.decide) b_q <= '0;
			else if (cmd.zero_step || cmd.walk_step) b_q <= b_q + TW'(1);
			v_s1 <= cmd.walk_step;
			v_s2 <= v_s1;
		end
	end

	// query walk: target reached when (running sum + 1) * 10000 > count * percent
	assign acc_next = acc_q + ACW'(prod_s2);

	always_ff @(posedge clk) begin
		addr_s1  <= rd_addr;
		prod_s2  <= PW'(cnt_s1) * PW'(bhp_pkg::PERCENT_FULL);
		bound_s2 <= bound_s1;
		if (cmd.decide) begin
			n_q     <= meta_rd_q[TW-1:0];
			count_q <= stat_rd_q[95:64];
			sum_q   <= stat_rd_q[63:0];
			x_q     <= PW'(stat_rd_q[95:64]) * PW'(pclamp);
			acc_q   <= ACW'(bhp_pkg::PERCENT_FULL);
			found_q <= 1'b0;
			ans_q   <= '0;
			last_q  <= '0;
		end else if (v_s2) begin
			acc_q  <= acc_next;
			last_q <= bound_s2;
			if (!found_q && acc_next > ACW'(x_q)) begin
				found_q <= 1'b1;
				ans_q   <= bound_s2;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rsp_load) begin
			rsp_q.status <= cmd.rsp_status;
			rsp_q.answer <= (item_q.kind == bhp_pkg::KIND_QUERY
				&& cmd.rsp_status == bhp_pkg::STAT_OK) ?
				(found_q ? ans_q : last_q) : '0;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_comb begin
		sts.kind       = item_q.kind;
		sts.id_ok      = id_ok;
		sts.bidx_ok    = bidx_ok;
		sts.defined    = meta_rd_q[TW];
		sts.empty      = stat_rd_q[95:64] == 32'd0;
		sts.n_zero     = meta_rd_q[TW-1:0] == '0;
		sts.zero_last  = b_q == TW'(MAX_BUCKETS - 1);
		sts.walk_last  = b_q == n_q - TW'(1);
		sts.sweep_last = sweep_q == AW'(ENT - 1);
		sts.pipe_busy  = v_s1 || v_s2;
		sts.rsp_room   = !rsp_valid_q || !rsp_stall;
	end

endmodule
`default_nettype wire

@@ hdl/bucket_histogram_percentile.sv @@
// Top level of the bucket histogram percentile block.
`timescale 1ns / 1ps
`default_nettype none
// A bank of NUM_HISTOGRAMS cumulative histograms of up to MAX_BUCKETS buckets
// each, with Q16.16 bounds and saturating 32-bit counts. One request beat gives
// one response beat. The block handles one beat at a time: req_stall is low
// only while the controller is idle, and a finished response waits in the
// output register, so the next beat is taken and worked on while it waits; only
// the reply step holds until that register is free. Load bound and unused kinds
// end without a walk, as do observe or percentile on an undefined histogram and
// percentile on an empty one; set bucket total zeroes all MAX_BUCKETS counts of
// the histogram, one count zeroed per cycle; observe and percentile walk n
// buckets, none when n is zero, where n is the histogram's bucket total: the
// walk reads one bucket of the bound and count memories per cycle through a
// three-stage pipeline that must drain before the result is settled; clear all
// clears one count entry per cycle. The controller then returns to idle, where
// it can take the next beat. After reset the block runs a clearing pass over all
// NUM_HISTOGRAMS * MAX_BUCKETS count entries before it takes its first beat. The
// percentile target is tested as (running sum + 1) * 10000 > count * percent,
// which matches the floor-divided target without a divider.
module bucket_histogram_percentile #(
	parameter int NUM_HISTOGRAMS = 128,
	parameter int MAX_BUCKETS    = 32
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_stall,
	input  wire bhp_pkg::req_t req,
	output logic               rsp_valid,
	input  wire logic          rsp_stall,
	output bhp_pkg::rsp_t      rsp
);

	bhp_pkg::cmd_t cmd;
	bhp_pkg::sts_t sts;

	// sequence each beat
	bhp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// memories, walk and response register
	bhp_datapath #(
		.NUM_HISTOGRAMS (NUM_HISTOGRAMS),
		.MAX_BUCKETS    (MAX_BUCKETS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_stall (rsp_stall),
		.rsp_valid (rsp_valid),
		.rsp       (rsp)
	);

endmodule
`default_nettype wire

@@ hdl/bhp_checker.sv @@
// Port-level checks of the bucket histogram percentile block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module bhp_checker (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          req_valid,
	input wire logic          req_stall,
	input wire bhp_pkg::req_t req,
	input wire logic          rsp_valid,
	input wire logic          rsp_stall,
	input wire bhp_pkg::rsp_t rsp
);

	// one beat in flight: stall rises right after an accepted beat
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request accepted while a beat was in progress");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.status != 2'd3)
		else $error("response status outside the defined codes");

	a_answer_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != bhp_pkg::STAT_OK |-> rsp.answer == 32'sd0)
		else $error("nonzero answer with a failing status");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled response changed");

endmodule

bind bucket_histogram_percentile bhp_checker u_bhp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.req       (req),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);
`default_nettype wire
